[hdl/rtpal_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpal_pkg
// Shared widths, constants and types of the A-law RTP packetizer.
// ----------------------------------------------------------------------------
package rtpal_pkg;

   localparam int PCM_W  = 16;
   localparam int BYTE_W = 8;
   localparam int CNT_W  = 10;
   localparam int HIDX_W = 4;
   localparam int SEQ_W  = 16;
   localparam int TS_W   = 32;
   localparam int SSRC_W = 32;
   localparam int PT_W   = 7;

   localparam logic [CNT_W-1:0]  MAX_PAYLOAD = CNT_W'(1012);
   localparam logic [HIDX_W-1:0] HDR_LEN     = HIDX_W'(12);

   localparam logic [BYTE_W-1:0] RTP_V2_BYTE = 8'h80;
   localparam logic [BYTE_W-1:0] ALAW_XOR    = 8'h55;
   localparam logic [BYTE_W-1:0] ALAW_POS    = 8'h80;

   localparam logic [PT_W-1:0]   PT_RESET    = 7'd8;
   localparam logic [SEQ_W-1:0]  SEQ_RESET   = 16'd1;

   // configuration register indexes
   localparam logic CSR_SSRC = 1'b0;
   localparam logic CSR_PT   = 1'b1;

   typedef struct packed {
      logic              emit;   // a byte is offered this cycle
      logic              done;   // held sample retires this cycle
      logic [BYTE_W-1:0] data;
      logic              hdr;
      logic              pend;
   } step_type;

endpackage

[hdl/rtpal_alaw_enc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpal_alaw_enc
// G.711 A-law encoder for one signed 16-bit linear sample.
// ----------------------------------------------------------------------------
module rtpal_alaw_enc (
   input  logic signed [rtpal_pkg::PCM_W-1:0]  sample,
   output logic        [rtpal_pkg::BYTE_W-1:0] code
);
   import rtpal_pkg::*;

   logic        neg;
   logic [11:0] mag;
   logic [2:0]  seg;
   logic [3:0]  mant;

   // magnitude of a 16-bit sample never exceeds 4095
   always_comb begin
      neg = sample[PCM_W-1];
      mag = neg ? ~sample[PCM_W-2:3] : sample[PCM_W-2:3];
   end

   always_comb begin
      if (mag[11]) begin
         seg = 3'd7;
      end else if (mag[10]) begin
         seg = 3'd6;
      end else if (mag[9]) begin
         seg = 3'd5;
      end else if (mag[8]) begin
         seg = 3'd4;
      end else if (mag[7]) begin
         seg = 3'd3;
      end else if (mag[6]) begin
         seg = 3'd2;
      end else if (mag[5]) begin
         seg = 3'd1;
      end else begin
         seg = 3'd0;
      end
   end

   always_comb begin
      case (seg)
         3'd0, 3'd1: begin
            mant = mag[4:1];
         end
         3'd2: begin
            mant = mag[5:2];
         end
         3'd3: begin
            mant = mag[6:3];
         end
         3'd4: begin
            mant = mag[7:4];
         end
         3'd5: begin
            mant = mag[8:5];
         end
         3'd6: begin
            mant = mag[9:6];
         end
         default: begin
            mant = mag[10:7];
         end
      endcase
   end

   assign code = ({1'b0, seg, mant} ^ ALAW_XOR) | (neg ? '0 : ALAW_POS);

endmodule

[hdl/rtpal_framer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpal_framer
// Packet state (sequence, timestamp, payload count) and header sequencing.
// ----------------------------------------------------------------------------
module rtpal_framer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             item_valid,
   input  logic                             item_last,
   input  logic [rtpal_pkg::BYTE_W-1:0]     item_code,
   input  logic                             adv,
   input  logic [rtpal_pkg::SSRC_W-1:0]     ssrc,
   input  logic [rtpal_pkg::PT_W-1:0]       ptype,
   output rtpal_pkg::step_type              step
);
   import rtpal_pkg::*;

   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [TS_W-1:0]   ts_ff, ts_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [HIDX_W-1:0] hidx_ff, hidx_in;

   logic              need_hdr;
   logic              kept;
   logic [CNT_W-1:0]  count_inc;
   logic [CNT_W-1:0]  count_new;
   logic [BYTE_W-1:0] hdr_byte;

   always_comb begin
      need_hdr  = (count_ff == '0) && (hidx_ff != HDR_LEN);
      kept      = count_ff < MAX_PAYLOAD;
      count_inc = count_ff + CNT_W'(1);
      count_new = kept ? count_inc : count_ff;
   end

   always_comb begin
      case (hidx_ff)
         4'd0:    hdr_byte = RTP_V2_BYTE;
         4'd1:    hdr_byte = {1'b0, ptype};
         4'd2:    hdr_byte = seq_ff[15:8];
         4'd3:    hdr_byte = seq_ff[7:0];
         4'd4:    hdr_byte = ts_ff[31:24];
         4'd5:    hdr_byte = ts_ff[23:16];
         4'd6:    hdr_byte = ts_ff[15:8];
         4'd7:    hdr_byte = ts_ff[7:0];
         4'd8:    hdr_byte = ssrc[31:24];
         4'd9:    hdr_byte = ssrc[23:16];
         4'd10:   hdr_byte = ssrc[15:8];
         4'd11:   hdr_byte = ssrc[7:0];
         default: hdr_byte = '0;
      endcase
   end

   always_comb begin
      step.emit = item_valid && (need_hdr || kept);
      step.done = item_valid && !need_hdr && (!kept || adv);
      step.data = need_hdr ? hdr_byte : item_code;
      step.hdr  = need_hdr;
      step.pend = !need_hdr && (item_last || (count_inc == MAX_PAYLOAD));
   end

   always_comb begin
      seq_in   = seq_ff;
      ts_in    = ts_ff;
      count_in = count_ff;
      hidx_in  = hidx_ff;
      if (item_valid && need_hdr && adv) begin
         hidx_in = hidx_ff + HIDX_W'(1);
      end
      if (step.done) begin
         hidx_in  = '0;
         count_in = count_new;
         if (item_last) begin
            seq_in   = seq_ff + SEQ_W'(1);
            ts_in    = ts_ff + TS_W'(count_new);
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= SEQ_RESET;
         ts_ff    <= '0;
         count_ff <= '0;
         hidx_ff  <= '0;
      end else begin
         seq_ff   <= seq_in;
         ts_ff    <= ts_in;
         count_ff <= count_in;
         hidx_ff  <= hidx_in;
      end
   end

   a_hidx_range: assert property (@(posedge clock) disable iff (reset)
      hidx_ff <= HDR_LEN)
      else $error("header index out of range");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_PAYLOAD)
      else $error("payload count above cap");

   a_hdr_only_at_start: assert property (@(posedge clock) disable iff (reset)
      hidx_ff != '0 |-> count_ff == '0)
      else $error("header in progress mid frame");

   a_hdr_no_end: assert property (@(posedge clock) disable iff (reset)
      step.emit && step.hdr |-> !step.pend && !step.done)
      else $error("header byte marked as packet end");

endmodule

[hdl/rtp_alaw_packetizer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_alaw_packetizer_unit
// Encodes PCM samples to A-law and emits RTP packets one byte per word.
// ----------------------------------------------------------------------------
// an accepted sample is held in the hold register, then its first byte in rsp
// throughput: 1 sample per cycle inside a frame while rsp does not stall; the first
//   sample of a frame holds the input while the header bytes go out
// samples past the payload cap retire with no output
// synchronous reset: sequence 1, timestamp 0, ssrc 0, payload type 8
module rtp_alaw_packetizer_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rtpal_pkg::PCM_W-1:0]       req_tdata,   // sample
   input  logic                              req_tlast,   // frame_end
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rtpal_pkg::BYTE_W-1:0]      rsp_tdata,   // packet_byte
   output logic                              rsp_tuser,   // is_header
   output logic                              rsp_tlast,   // packet_end
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [rtpal_pkg::SSRC_W-1:0]      csr_wdata
);
   import rtpal_pkg::*;

   logic [SSRC_W-1:0] ssrc_ff;
   logic [PT_W-1:0]   pt_ff;

   logic              hold_valid_ff, hold_valid_in;
   logic [PCM_W-1:0]  hold_sample_ff, hold_sample_in;
   logic              hold_last_ff, hold_last_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_hdr_ff, rsp_hdr_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              adv;
   logic              req_fire;
   logic [BYTE_W-1:0] code;
   step_type          step;

   always_ff @(posedge clock) begin
      if (reset) begin
         ssrc_ff <= '0;
         pt_ff   <= PT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SSRC: ssrc_ff <= csr_wdata;
            CSR_PT:   pt_ff   <= csr_wdata[PT_W-1:0];
            default:  ;
         endcase
      end
   end

   rtpal_alaw_enc u_enc (
      .sample (hold_sample_ff),
      .code   (code)
   );

   rtpal_framer u_framer (
      .clock      (clock),
      .reset      (reset),
      .item_valid (hold_valid_ff),
      .item_last  (hold_last_ff),
      .item_code  (code),
      .adv        (adv),
      .ssrc       (ssrc_ff),
      .ptype      (pt_ff),
      .step       (step)
   );

   always_comb begin
      adv        = !rsp_valid_ff || rsp_tready;
      req_tready = !hold_valid_ff || step.done;
      req_fire   = req_tvalid && req_tready;

      hold_valid_in  = hold_valid_ff;
      hold_sample_in = hold_sample_ff;
      hold_last_in   = hold_last_ff;
      if (req_fire) begin
         hold_valid_in  = 1'b1;
         hold_sample_in = req_tdata;
         hold_last_in   = req_tlast;
      end else if (step.done) begin
         hold_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_hdr_in   = rsp_hdr_ff;
      rsp_last_in  = rsp_last_ff;
      if (adv) begin
         rsp_valid_in = step.emit;
         rsp_data_in  = step.data;
         rsp_hdr_in   = step.hdr;
         rsp_last_in  = step.pend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      hold_sample_ff <= hold_sample_in;
      hold_last_ff   <= hold_last_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_hdr_ff     <= rsp_hdr_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hdr_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff)
      else $error("pending word dropped");

   a_hold_kept: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff && !step.done |=> hold_valid_ff && $stable(hold_sample_ff))
      else $error("held sample lost before retiring");

   a_hdr_first_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_tlast |-> !rsp_tuser)
      else $error("header word carries packet end");

endmodule

[tb/rtp_alaw_packetizer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_alaw_packetizer_unit_tb
// Streams PCM frames into the packetizer under random source bursts and sink
// stalls, and checks every packet word against a local A-law / RTP packet
// predictor. A short table of directed samples comes first, then random
// frames under several SSRC and payload type settings, including one frame
// that reaches and overruns the payload cap.
// ----------------------------------------------------------------------------
module rtp_alaw_packetizer_unit_tb;
   import rtpal_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              hdr;
      logic              pend;
   } rtp_word_type;

   typedef struct packed {
      logic [PCM_W-1:0]  pcm;
      logic              last;
      logic              typed;
      logic [BYTE_W-1:0] code;
   } pcm_row_type;

   localparam int DIR_ROWS = 22;
   localparam int CAP      = int'(MAX_PAYLOAD);

   // typed code only where it is obvious: zero, full scale, minus one
   pcm_row_type pcm_table [0:DIR_ROWS-1] = '{
      '{16'h0000, 1'b0, 1'b1, 8'hD5},
      '{16'h7FFF, 1'b0, 1'b1, 8'hAA},
      '{16'h8000, 1'b0, 1'b1, 8'h2A},
      '{16'hFFFF, 1'b1, 1'b1, 8'h55},
      '{16'h0001, 1'b1, 1'b0, 8'h00},
      '{16'h00F8, 1'b0, 1'b0, 8'h00},
      '{16'h0100, 1'b0, 1'b0, 8'h00},
      '{16'h01F8, 1'b0, 1'b0, 8'h00},
      '{16'h0200, 1'b0, 1'b0, 8'h00},
      '{16'h0400, 1'b0, 1'b0, 8'h00},
      '{16'h0800, 1'b0, 1'b0, 8'h00},
      '{16'h1000, 1'b0, 1'b0, 8'h00},
      '{16'h2000, 1'b0, 1'b0, 8'h00},
      '{16'h4000, 1'b1, 1'b0, 8'h00},
      '{16'hFF07, 1'b0, 1'b0, 8'h00},
      '{16'hFEFF, 1'b0, 1'b0, 8'h00},
      '{16'hFDFF, 1'b0, 1'b0, 8'h00},
      '{16'hFBFF, 1'b0, 1'b0, 8'h00},
      '{16'hF7FF, 1'b0, 1'b0, 8'h00},
      '{16'hEFFF, 1'b0, 1'b0, 8'h00},
      '{16'hDFFF, 1'b0, 1'b0, 8'h00},
      '{16'hBFFF, 1'b1, 1'b0, 8'h00}
   };

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [PCM_W-1:0]    req_tdata;
   logic                req_tlast;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [BYTE_W-1:0]   rsp_tdata;
   logic                rsp_tuser;
   logic                rsp_tlast;
   logic                csr_wr_en;
   logic                csr_index;
   logic [SSRC_W-1:0]   csr_wdata;

   // packet predictor state
   logic [SSRC_W-1:0]   ssrc_cfg;
   logic [PT_W-1:0]     pt_cfg;
   logic [SEQ_W-1:0]    seq_num;
   logic [TS_W-1:0]     media_ts;
   int                  kept_cnt;
   rtp_word_type        packet_words [$];

   int                  fail_count;
   int                  burst_left;
   int                  gap_left;
   bit                  gapless;
   bit                  hold_off_req;

   rtp_alaw_packetizer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // sample
      .req_tlast  (req_tlast),    // frame_end
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // packet_byte
      .rsp_tuser  (rsp_tuser),    // is_header
      .rsp_tlast  (rsp_tlast),    // packet_end
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic logic [BYTE_W-1:0] alaw_of(input logic [PCM_W-1:0] pcm);
      logic [PCM_W-1:0]  folded;
      logic [12:0]       mag;
      int                seg;
      logic [3:0]        mant;
      logic [BYTE_W-1:0] code;
      // negative samples fold by one's complement, so the top bit is clear
      folded = pcm[PCM_W-1] ? ~pcm : pcm;
      mag = folded[PCM_W-1:3];
      seg = 0;
      while (seg < 7 && mag >= (13'd32 << seg)) seg++;
      if (seg < 2) begin
         mant = mag[4:1];
      end else begin
         mant = 4'(mag >> seg);
      end
      code = {1'b0, 3'(seg), mant} ^ ALAW_XOR;
      if (!pcm[PCM_W-1]) code = code | ALAW_POS;
      return code;
   endfunction

   task automatic predict_packet(input logic [PCM_W-1:0] pcm, input logic last,
                                 input logic typed, input logic [BYTE_W-1:0] code);
      logic [95:0]  hdr_bits;
      rtp_word_type w;
      if (kept_cnt == 0) begin
         hdr_bits = {RTP_V2_BYTE, 1'b0, pt_cfg, seq_num, media_ts, ssrc_cfg};
         for (int k = 0; k < 12; k++) begin
            w.data = hdr_bits[95 - 8*k -: 8];
            w.hdr  = 1'b1;
            w.pend = 1'b0;
            packet_words.push_back(w);
         end
      end
      // samples past the cap are dropped
      if (kept_cnt < CAP) begin
         kept_cnt++;
         w.data = typed ? code : alaw_of(pcm);
         w.hdr  = 1'b0;
         w.pend = last || (kept_cnt >= CAP);
         packet_words.push_back(w);
      end
      if (last) begin
         seq_num  = seq_num + 1'b1;
         media_ts = media_ts + TS_W'(kept_cnt);
         kept_cnt = 0;
      end
   endtask

   task automatic write_csr(input logic idx, input logic [SSRC_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_SSRC) begin
         ssrc_cfg = val;
      end else begin
         pt_cfg = val[PT_W-1:0];
      end
      @(negedge clock);
   endtask

   task automatic set_config(input logic [SSRC_W-1:0] ssrc, input logic [PT_W-1:0] pt);
      write_csr(CSR_SSRC, ssrc);
      write_csr(CSR_PT, SSRC_W'(pt));
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_pcm(input logic [PCM_W-1:0] pcm, input logic last,
                           input logic typed, input logic [BYTE_W-1:0] code);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap_left = (gapless || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap_left) @(negedge clock);
         gap_left = 0;
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pcm;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_packet(pcm, last, typed, code);
      burst_left--;
      @(negedge clock);
   endtask

   function automatic logic [PCM_W-1:0] rand_pcm();
      case ($urandom_range(0, 5))
         0, 1, 2: return PCM_W'($urandom);
         3:       return PCM_W'($urandom_range(0, 511));
         4:       return PCM_W'(-$urandom_range(1, 512));
         default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      endcase
   endfunction

   task automatic send_frame(input int len);
      for (int i = 0; i < len; i++) begin
         send_pcm(rand_pcm(), i == len - 1, 1'b0, 8'h00);
      end
   endtask

   task automatic run_traffic(input int n_items);
      int sent;
      int len;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 16);
         if (len > n_items - sent) len = n_items - sent;
         send_frame(len);
         sent += len;
      end
   endtask

   // idle the source and let the last words and any dropped samples clear
   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (packet_words.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // sink stalls: always ready, random, or a repeating pattern, plus a long hold-off on request
   initial begin
      int mode;
      int span;
      int pat_len;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
         end
         mode    = $urandom_range(0, 2);
         span    = $urandom_range(8, 64);
         pat_len = $urandom_range(2, 5);
         for (int i = 0; i < span; i++) begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 2) != 0);
               default: rsp_tready <= ((i % pat_len) != 0);
            endcase
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rtp_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (packet_words.size() == 0) begin
            $error("unexpected word: data %h hdr %b end %b", rsp_tdata, rsp_tuser, rsp_tlast);
            fail_count++;
         end else begin
            w = packet_words.pop_front();
            if (rsp_tdata !== w.data) begin
               $error("packet_byte: expected %h, actual %h", w.data, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser !== w.hdr) begin
               $error("is_header: expected %b, actual %b", w.hdr, rsp_tuser);
               fail_count++;
            end
            if (rsp_tlast !== w.pend) begin
               $error("packet_end: expected %b, actual %b", w.pend, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      csr_wr_en    = 1'b0;
      csr_index    = CSR_SSRC;
      csr_wdata    = '0;
      fail_count   = 0;
      burst_left   = 0;
      gap_left     = 0;
      gapless      = 1'b0;
      hold_off_req = 1'b0;
      ssrc_cfg     = '0;
      pt_cfg       = PT_RESET;
      seq_num      = SEQ_RESET;
      media_ts     = '0;
      kept_cnt     = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed samples under the reset configuration
      for (int r = 0; r < DIR_ROWS; r++) begin
         send_pcm(pcm_table[r].pcm, pcm_table[r].last, pcm_table[r].typed,
                  pcm_table[r].code);
      end
      settle();

      set_config(32'hFFFF_FFFF, 7'd127);
      hold_off_req = 1'b1;
      run_traffic(38);
      settle();

      // payload cap: a frame that overruns it
      set_config(32'h0000_0000, 7'd0);
      run_traffic(15);
      send_frame(CAP + $urandom_range(1, 5));
      run_traffic(15);
      settle();

      set_config($urandom, PT_W'($urandom_range(0, 127)));
      gapless = 1'b1;
      run_traffic(40);
      settle();

      set_config($urandom, PT_RESET);
      gapless = 1'b0;
      run_traffic(40);
      settle();

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
